// File: hdl/vln_pkg.sv
// Shared types and constants of the L2 vector normalizer.
`default_nettype none

package vln_pkg;

	localparam int SUM_W     = 37;             // sum of squares, wraps
	localparam int LEN_W     = 27;             // length, Q.8
	localparam int DIM_W     = 7;              // vector_dim register
	localparam int Q_W       = 16;             // Q1.15 result
	localparam int FRAC_SH   = 16;             // sum << 16 puts the root in Q.8
	localparam int Q_SHIFT   = 23;             // element << 23 / length gives Q1.15
	localparam int PRE_SH    = Q_SHIFT - Q_W;  // dividend bits above the quotient
	localparam int X_W       = 2 * LEN_W;      // radicand, two bits per root bit
	localparam int REM_W     = LEN_W + 3;      // root remainder
	localparam int SQ_STEPS  = LEN_W;          // one root bit per step
	localparam int SQ_CW     = $clog2(SQ_STEPS + 1);
	localparam int DIV_CW    = $clog2(Q_W + 1);

	localparam int CFG_IW    = 1;
	localparam int CFG_DW    = LEN_W;

	localparam logic [CFG_IW-1:0] REG_VECTOR_DIM = 1'b0;
	localparam logic [CFG_IW-1:0] REG_MIN_LENGTH = 1'b1;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	typedef logic [LEN_W-1:0] len_t;
	typedef logic [Q_W-1:0]   q15_t;
	typedef logic [SUM_W-1:0] sum_t;

	localparam q15_t Q_POS_MAX = 16'h7FFF;
	localparam q15_t Q_NEG_MAG = 16'h8000;

endpackage

`default_nettype wire

// File: hdl/vln_if.sv
// Stream interfaces: element input channel and normalized result channel.
`default_nettype none

interface vln_in_if #(
	parameter int ELEMENT_BITS = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [ELEMENT_BITS-1:0] element_value;
	logic                           batch_end;

	modport source (output valid, output element_value, output batch_end, input ready);
	modport sink   (input valid, input element_value, input batch_end, output ready);
endinterface

interface vln_out_if
	import vln_pkg::*;
;
	logic               valid;
	logic               ready;
	logic signed [Q_W-1:0] normalized_value;
	len_t               vector_length;
	logic               last_of_vector;
	logic               batch_done;

	modport source (output valid, output normalized_value, output vector_length,
		output last_of_vector, output batch_done, input ready);
	modport sink   (input valid, input normalized_value, input vector_length,
		input last_of_vector, input batch_done, output ready);
endinterface

`default_nettype wire

// File: hdl/vln_isqrt.sv
// Bit-serial integer square root of (sum << 16), one root bit per cycle.
`default_nettype none

module vln_isqrt
	import vln_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire sum_t sum,
	output logic      done,
	output len_t      root
);

	logic             busy_q;
	logic             done_q;
	logic [SQ_CW-1:0] cnt_q;
	logic [X_W-1:0]   x_q;
	logic [REM_W-1:0] rem_q;
	len_t             root_q;

	logic [REM_W-1:0] r2;
	logic [REM_W-1:0] trial;
	logic             ge;

	assign r2    = {rem_q[REM_W-3:0], x_q[X_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (r2 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQ_CW'(SQ_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - SQ_CW'(1);
				if (cnt_q == SQ_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= X_W'({sum, FRAC_SH'(0)});
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[X_W-3:0], 2'b00};
			rem_q  <= ge ? (r2 - trial) : r2;
			root_q <= {root_q[LEN_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// File: hdl/vln_div.sv
// Restoring serial divider: element / length in Q1.15, one quotient bit per cycle.
`default_nettype none

module vln_div
	import vln_pkg::*;
#(
	parameter int ELEMENT_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic signed [ELEMENT_BITS-1:0] elem,
	input  wire len_t                           len,
	output logic                                done,
	output q15_t                                quot
);

	localparam int EB    = ELEMENT_BITS;
	localparam int SC_W  = EB + PRE_SH;
	localparam int CMP_W = (SC_W > LEN_W) ? SC_W : LEN_W;

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              neg_q;
	logic              ovf_q;
	len_t              rem_q;
	q15_t              q_q;

	logic [EB-1:0]     elem_u;
	logic              neg;
	logic [EB-1:0]     mag;
	logic [SC_W-1:0]   scaled;
	logic              ovf;
	logic [LEN_W:0]    t;
	logic [LEN_W:0]    len_x;
	logic              ge;
	q15_t              neg_mag;

	assign elem_u = elem;
	assign neg    = elem[EB-1];
	assign mag    = neg ? (~elem_u + EB'(1)) : elem_u;
	assign scaled = {mag, PRE_SH'(0)};
	// quotient of 2^16 or more saturates either way
	assign ovf    = (CMP_W'(scaled) >= CMP_W'(len));

	assign t     = {rem_q, 1'b0};
	assign len_x = {1'b0, len};
	assign ge    = (t >= len_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !ovf;
				done_q <= ovf;
				cnt_q  <= DIV_CW'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CW'(1);
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= neg;
			ovf_q <= ovf;
			rem_q <= LEN_W'(scaled);
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? LEN_W'(t - len_x) : LEN_W'(t);
			q_q   <= {q_q[Q_W-2:0], ge};
		end
	end

	always_comb begin
		neg_mag = (ovf_q || (q_q > Q_NEG_MAG)) ? Q_NEG_MAG : q_q;
		if (neg_q)
			quot = ~neg_mag + Q_W'(1);
		else if (ovf_q || q_q[Q_W-1])
			quot = Q_POS_MAX;
		else
			quot = q_q;
	end

	assign done = done_q;

endmodule

`default_nettype wire

// File: hdl/vector_l2_normalizer_core.sv
// Top level of the L2 vector normalizer: buffer, serial squarer, sequencer, output register.
//
//  channel   dir  flow          payload
//  din       in   valid/ready   element_value (ELEMENT_BITS, signed), batch_end
//  dout      out  valid/ready   normalized_value (16, signed), vector_length (27),
//                               last_of_vector, batch_done
//  cfg_*     in   we only       cfg_index (0 vector_dim, 1 min_length), cfg_wdata (27)
//
// Each element transfer is followed by the sum-of-squares update, built by a
// shift-add squarer that looks at one multiplier bit per cycle. The element
// that completes a vector adds a 27-step bit-serial square root; then each
// result takes a buffer read, a load, the 16-step serial divider when scaled
// (skipped when not scaled, cut short when the quotient saturates) and the
// issue to the output register; a stalled dout holds the sequencer.
// Reset clears the control state; vector_dim returns to 64 and min_length to 0.
// The element buffer is not cleared: every entry is written before it is read.
`default_nettype none

module vector_l2_normalizer_core
	import vln_pkg::*;
#(
	parameter int MAX_DIM      = 64,
	parameter int ELEMENT_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	vln_in_if.sink                 din,
	vln_out_if.source              dout
);

	localparam int EB  = ELEMENT_BITS;
	localparam int AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;  // buffer address
	localparam int CW  = $clog2(MAX_DIM + 1);                  // element count
	localparam int MCW = $clog2(EB + 1);                       // squarer steps

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an element
	localparam logic [2:0] S_SQR  = 3'd1;  // serial square and accumulate
	localparam logic [2:0] S_ROOT = 3'd2;  // square root running
	localparam logic [2:0] S_RD   = 3'd3;  // buffer read issued
	localparam logic [2:0] S_LOAD = 3'd4;  // buffer data back, pick path
	localparam logic [2:0] S_DIV  = 3'd5;  // divider running
	localparam logic [2:0] S_OUT  = 3'd6;  // hand result to output register

	// ---------------- configuration ----------------
	logic [DIM_W-1:0] vector_dim_q;
	len_t             min_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_dim_q <= DIM_RESET;
			min_length_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VECTOR_DIM: vector_dim_q <= cfg_wdata[DIM_W-1:0];
				REG_MIN_LENGTH: min_length_q <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// dimension 0 acts as 1, anything above the buffer depth as the depth
	logic [DIM_W-1:0] dim_eff;
	always_comb begin
		if (vector_dim_q == '0)
			dim_eff = DIM_W'(1);
		else if (vector_dim_q > DIM_W'(MAX_DIM))
			dim_eff = DIM_W'(MAX_DIM);
		else
			dim_eff = vector_dim_q;
	end

	// ---------------- state ----------------
	logic [2:0]     state_q;
	logic [CW-1:0]  count_q;     // elements buffered
	logic           flag_q;      // batch_end seen in this vector
	logic           cmp_q;       // current element completes the vector
	logic [MCW-1:0] sq_cnt_q;
	sum_t           sum_q;
	logic [AW-1:0]  k_q;         // result index
	logic           ov_q;        // output register full
	logic           root_start_q;

	// payload
	sum_t                   mcand_q;
	logic [EB-1:0]          mplier_q;
	len_t                   len_q;
	logic                   scale_q;
	q15_t                   res_q;
	logic signed [EB-1:0]   rd_q;
	logic signed [EB-1:0]   mem [MAX_DIM];
	q15_t                   out_val_q;
	len_t                   out_len_q;
	logic                   out_last_q;
	logic                   out_bdone_q;

	// ---------------- input side ----------------
	logic          in_xfer;
	logic [EB-1:0] in_u;
	logic [EB-1:0] in_mag;
	logic          in_done;

	assign din.ready = (state_q == S_IDLE);
	assign in_xfer   = din.valid && din.ready;
	assign in_u      = din.element_value;
	assign in_mag    = din.element_value[EB-1] ? (~in_u + EB'(1)) : in_u;
	assign in_done   = ((DIM_W'(count_q) + DIM_W'(1)) >= dim_eff);

	// ---------------- arithmetic units ----------------
	logic root_done;
	len_t root;
	logic div_start;
	logic div_done;
	q15_t div_quot;

	vln_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start_q),
		.sum    (sum_q),
		.done   (root_done),
		.root   (root)
	);

	assign div_start = (state_q == S_LOAD) && scale_q;

	vln_div #(
		.ELEMENT_BITS (EB)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.elem   (rd_q),
		.len    (len_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// unscaled path: raw element sign-extended or cut to 16 bits
	logic [EB+Q_W-1:0] rd_ext;
	q15_t              raw16;
	assign rd_ext = {{Q_W{rd_q[EB-1]}}, rd_q};
	assign raw16  = rd_ext[Q_W-1:0];

	// ---------------- output side ----------------
	logic out_load;
	logic last_k;

	assign last_k   = ((CW'(k_q) + CW'(1)) == count_q);
	assign out_load = (state_q == S_OUT) && (!ov_q || dout.ready);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			flag_q       <= 1'b0;
			cmp_q        <= 1'b0;
			sq_cnt_q     <= '0;
			sum_q        <= '0;
			k_q          <= '0;
			ov_q         <= 1'b0;
			root_start_q <= 1'b0;
		end else begin
			root_start_q <= 1'b0;
			if (out_load)
				ov_q <= 1'b1;
			else if (dout.ready)
				ov_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						count_q  <= count_q + CW'(1);
						flag_q   <= flag_q | din.batch_end;
						cmp_q    <= in_done;
						sq_cnt_q <= MCW'(EB);
						state_q  <= S_SQR;
					end
				end
				S_SQR: begin
					if (mplier_q[0])
						sum_q <= sum_q + mcand_q;
					sq_cnt_q <= sq_cnt_q - MCW'(1);
					if (sq_cnt_q == MCW'(1)) begin
						if (cmp_q) begin
							root_start_q <= 1'b1;
							state_q      <= S_ROOT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ROOT: begin
					if (root_done) begin
						k_q     <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_LOAD;
				S_LOAD: state_q <= scale_q ? S_DIV : S_OUT;
				S_DIV: begin
					if (div_done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						if (last_k) begin
							sum_q   <= '0;
							count_q <= '0;
							flag_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mem[count_q[AW-1:0]] <= din.element_value;
			mcand_q              <= SUM_W'(in_mag);
			mplier_q             <= in_mag;
		end else if (state_q == S_SQR) begin
			mcand_q  <= {mcand_q[SUM_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[EB-1:1]};
		end

		rd_q <= mem[k_q];

		if (state_q == S_ROOT && root_done) begin
			len_q   <= root;
			scale_q <= (root > min_length_q);
		end

		if (state_q == S_LOAD && !scale_q)
			res_q <= raw16;
		else if (state_q == S_DIV && div_done)
			res_q <= div_quot;

		if (out_load) begin
			out_val_q   <= res_q;
			out_len_q   <= scale_q ? len_q : '0;
			out_last_q  <= last_k;
			out_bdone_q <= last_k && flag_q;
		end
	end

	assign dout.valid            = ov_q;
	assign dout.normalized_value = out_val_q;
	assign dout.vector_length    = out_len_q;
	assign dout.last_of_vector   = out_last_q;
	assign dout.batch_done       = out_bdone_q;

	// ---------------- checks ----------------
	a_root_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> (state_q == S_ROOT))
		else $error("square root finished outside its wait state");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside its wait state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_DIM))
		else $error("element count beyond buffer depth");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_k) |=> (state_q == S_IDLE && count_q == '0 && sum_q == '0))
		else $error("vector state not cleared after its last result");

endmodule

`default_nettype wire

// File: dv/vector_l2_normalizer_core_tb.sv
// Self-checking testbench of the L2 vector normalizer core.
`timescale 1ns / 100ps

module vector_l2_normalizer_core_tb;
	import vln_pkg::*;

	localparam int MAX_DIM     = 64;
	localparam int ELEM_W      = 16;
	localparam int CYCLE_LIMIT = 500000;
	// Longest quiet stretch the core can spend on an element that completes nothing
	// (squarer) plus margin; used before register writes and at the end.
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_ITEMS = 400;
	localparam int QUIET_FROM   = 340;
	localparam logic [CFG_DW-1:0] MIN_LENGTH_TOP = 27'd67108864;

	typedef struct packed {
		q15_t value;
		len_t length;
		logic last;
		logic done;
	} norm_result_t;

	typedef logic signed [LEN_W:0] rpt_t;

	// Mirrors the core: buffers elements, builds the sum of squares and, on the
	// element that completes a vector, queues one expected transfer per element.
	class l2_scoreboard;
		logic signed [ELEM_W-1:0] held [MAX_DIM];
		sum_t                     sq_acc;
		int unsigned              held_n;
		logic                     batch_seen;
		logic [DIM_W-1:0]         dim_reg;
		len_t                     min_len_reg;
		norm_result_t             expected_q [$];
		int                       errors;

		function new();
			sq_acc      = '0;
			held_n      = 0;
			batch_seen  = 1'b0;
			dim_reg     = DIM_RESET;
			min_len_reg = '0;
			errors      = 0;
		endfunction

		function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
			if (idx == REG_VECTOR_DIM)
				dim_reg = val[DIM_W-1:0];
			else
				min_len_reg = val;
		endfunction

		// Floor of sqrt(sum << 16), i.e. the length in Q.8, found bit by bit.
		function len_t floor_root_q8(sum_t s);
			longint unsigned radicand;
			longint unsigned trial;
			len_t            root;
			radicand = 64'(s) << FRAC_SH;
			root = '0;
			for (int i = LEN_W - 1; i >= 0; i--) begin
				trial = 64'(root) | (64'd1 << i);
				if (trial * trial <= radicand)
					root = trial[LEN_W-1:0];
			end
			return root;
		endfunction

		// element / length in Q1.15, truncated toward zero, saturated.
		function q15_t scaled_q15(logic signed [ELEM_W-1:0] e, len_t len);
			longint          se;
			longint unsigned mag;
			longint unsigned q;
			se  = e;
			mag = (se < 0) ? -se : se;
			q   = (mag << Q_SHIFT) / 64'(len);
			if (se < 0) begin
				if (q > 64'(Q_NEG_MAG))
					q = 64'(Q_NEG_MAG);
				q = -q;
				return q[Q_W-1:0];
			end
			if (q > 64'(Q_POS_MAX))
				q = 64'(Q_POS_MAX);
			return q[Q_W-1:0];
		endfunction

		function void note_element(logic signed [ELEM_W-1:0] v, logic be);
			longint       se;
			int unsigned  dim_eff;
			len_t         len;
			logic         scale;
			norm_result_t r;
			se = v;
			// dimension 0 behaves as 1, anything past the buffer as a full buffer
			dim_eff = (dim_reg == 0) ? 1 : ((dim_reg > MAX_DIM) ? MAX_DIM : dim_reg);
			if (held_n >= MAX_DIM)
				held_n = MAX_DIM - 1;
			held[held_n] = v;
			held_n++;
			sq_acc = sq_acc + sum_t'(se * se);
			if (be)
				batch_seen = 1'b1;
			if (held_n < dim_eff)
				return;
			// a lowered dimension may release more elements than it names
			len   = floor_root_q8(sq_acc);
			scale = len > min_len_reg;
			for (int k = 0; k < held_n; k++) begin
				r.value  = scale ? scaled_q15(held[k], len) : q15_t'(held[k]);
				r.length = scale ? len : '0;
				r.last   = (k == held_n - 1);
				r.done   = r.last && batch_seen;
				expected_q.insert(expected_q.size(), r);
			end
			sq_acc     = '0;
			held_n     = 0;
			batch_seen = 1'b0;
		endfunction

		function void mismatch(string field, rpt_t want, rpt_t got);
			errors++;
			$error("%s: expected %0d, got %0d", field, want, got);
		endfunction

		function void check_result(q15_t nv, len_t vl, logic lv, logic bd);
			norm_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$error("unexpected transfer: normalized_value %0d vector_length %0d",
					$signed(nv), vl);
				return;
			end
			want = expected_q.pop_front();
			if (nv !== want.value)
				mismatch("normalized_value", rpt_t'($signed(want.value)),
					rpt_t'($signed(nv)));
			if (vl !== want.length)
				mismatch("vector_length", rpt_t'(want.length), rpt_t'(vl));
			if (lv !== want.last)
				mismatch("last_of_vector", rpt_t'(want.last), rpt_t'(lv));
			if (bd !== want.done)
				mismatch("batch_done", rpt_t'(want.done), rpt_t'(bd));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_IW-1:0]   cfg_index;
	logic [CFG_DW-1:0]   cfg_wdata;

	vln_in_if #(.ELEMENT_BITS(ELEM_W)) din_if ();
	vln_out_if                         dout_if ();

	vector_l2_normalizer_core #(
		.MAX_DIM      (MAX_DIM),
		.ELEMENT_BITS (ELEM_W)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.din       (din_if),
		.dout      (dout_if)
	);

	l2_scoreboard sb = new();

	// Pacing knobs, changed per phase. quiet turns all idling off for the tail.
	int   sink_stall_pct = 0;
	int   source_gap_pct = 0;
	bit   quiet          = 1'b0;
	int   cycles         = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung core or a lost transfer ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("vector_l2_normalizer_core_tb: FAIL");
			$finish;
		end
	end

	// Result side: ready drops in bursts at a per-phase rate.
	initial begin : sink_pacing
		int hold;
		hold = 0;
		dout_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold == 0 && !quiet && arst_n === 1'b1 &&
					$urandom_range(99) < sink_stall_pct)
				hold = $urandom_range(1, 10);
			if (hold != 0) begin
				dout_if.ready <= 1'b0;
				hold--;
			end else begin
				dout_if.ready <= 1'b1;
			end
		end
	end

	// Every completed result transfer goes against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && dout_if.valid === 1'b1 && dout_if.ready === 1'b1)
			sb.check_result(dout_if.normalized_value, dout_if.vector_length,
				dout_if.last_of_vector, dout_if.batch_done);
	end

	// One element transfer, optionally after an idle burst on the input side.
	// valid stays high after the transfer so back-to-back items need no toggle.
	task automatic send_element(input logic signed [ELEM_W-1:0] value, input logic be);
		if (!quiet && $urandom_range(99) < source_gap_pct) begin
			din_if.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		din_if.valid         <= 1'b1;
		din_if.element_value <= value;
		din_if.batch_end     <= be;
		do @(posedge clk); while (din_if.ready !== 1'b1);
		sb.note_element(value, be);
	endtask

	// Wait for every outstanding result, then let a pending squarer pass finish.
	task automatic drain();
		din_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller drops it after its last write.
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// Registers change only with the core idle.
	task automatic configure(input logic [DIM_W-1:0] dim, input logic [CFG_DW-1:0] min_len);
		drain();
		write_reg(REG_VECTOR_DIM, CFG_DW'(dim));
		write_reg(REG_MIN_LENGTH, min_len);
		cfg_we <= 1'b0;
	endtask

	// Element value by phase profile: full range, small, corner values, or a mix.
	function automatic logic signed [ELEM_W-1:0] pick_element(int profile);
		int p;
		p = (profile == 3) ? $urandom_range(0, 2) : profile;
		case (p)
			0: return ELEM_W'($urandom_range(0, 65535));
			1: return ELEM_W'($urandom_range(0, 127)) - 16'sd64;
			default: begin
				case ($urandom_range(0, 4))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					2: return 16'sd0;
					3: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
		endcase
	endfunction

	initial begin : stimulus
		int random_sent;
		int pick;
		int dim_eff;
		int vec_cnt;
		int n_items;
		int profile;
		logic [DIM_W-1:0]  dim;
		logic [CFG_DW-1:0] min_len;

		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= REG_VECTOR_DIM;
		cfg_wdata            <= '0;
		din_if.valid         <= 1'b0;
		din_if.element_value <= '0;
		din_if.batch_end     <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// One-element vectors: each quotient reaches 1.0 in magnitude, so positive
		// values saturate and 0x8000 gives -1.0; zero has length 0 and passes through raw.
		sink_stall_pct = 10;
		source_gap_pct = 20;
		configure(7'd1, '0);
		send_element(16'sh7FFF, 1'b0);
		send_element(16'sh8000, 1'b0);
		send_element(16'sd0, 1'b0);
		send_element(16'sd1, 1'b1);

		// Two-element vectors; batch_end on the first element still marks the last.
		configure(7'd2, '0);
		send_element(16'sd3, 1'b1);
		send_element(16'sd4, 1'b0);
		send_element(-16'sd1, 1'b0);
		send_element(16'sd1, 1'b0);
		send_element(16'sh8000, 1'b1);
		send_element(16'sh7FFF, 1'b1);

		// Threshold: 100 has length 25600 in Q.8; equal means not scaled.
		configure(7'd1, 27'd25600);
		send_element(16'sd100, 1'b0);
		send_element(-16'sd101, 1'b0);
		configure(7'd1, 27'd25599);
		send_element(16'sd100, 1'b1);
		configure(7'd1, MIN_LENGTH_TOP);
		send_element(16'sh8000, 1'b0);

		// Dimension 0 acts as 1.
		configure(7'd0, '0);
		send_element(16'sd5, 1'b0);
		send_element(-16'sd7, 1'b1);

		// Dimension lowered mid-vector: five buffered, dim 3, next one releases six.
		configure(7'd8, '0);
		repeat (5) send_element(pick_element(0), 1'($urandom_range(0, 1)));
		configure(7'd3, '0);
		send_element(pick_element(0), 1'b0);

		// ---- random part ----
		// Opens with an oversized dimension (acts as 64) and the largest length.
		configure(7'd127, '0);
		for (int i = 0; i < MAX_DIM; i++)
			send_element(16'sh8000, i == MAX_DIM - 1);
		random_sent = MAX_DIM;

		while (random_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 29);
			if (pick == 0)
				dim = 7'd0;
			else if (pick == 1)
				dim = 7'd127;
			else if (pick == 2)
				dim = 7'd64;
			else if (pick == 3)
				dim = DIM_W'($urandom_range(65, 126));
			else if (pick <= 6)
				dim = DIM_W'($urandom_range(9, 32));
			else
				dim = DIM_W'($urandom_range(1, 8));

			pick = $urandom_range(0, 9);
			if (pick <= 3)
				min_len = '0;
			else if (pick == 4)
				min_len = MIN_LENGTH_TOP;
			else if (pick <= 6)
				min_len = CFG_DW'($urandom_range(0, 1 << 16));
			else
				min_len = CFG_DW'($urandom_range(0, 1 << 24));

			configure(dim, min_len);

			quiet = (random_sent >= QUIET_FROM);
			case ($urandom_range(0, 2))
				0: sink_stall_pct = 0;
				1: sink_stall_pct = 5;
				default: sink_stall_pct = 20;
			endcase
			case ($urandom_range(0, 2))
				0: source_gap_pct = 0;
				1: source_gap_pct = 10;
				default: source_gap_pct = 40;
			endcase

			dim_eff = (dim == 0) ? 1 : ((dim > MAX_DIM) ? MAX_DIM : dim);
			vec_cnt = (dim_eff > 16) ? 1 : $urandom_range(1, 6);
			n_items = vec_cnt * dim_eff;
			// now and then leave a vector unfinished for the next setting to pick up
			if (dim_eff > 1 && $urandom_range(0, 5) == 0)
				n_items += $urandom_range(1, dim_eff - 1);
			profile = $urandom_range(0, 3);

			for (int i = 0; i < n_items; i++)
				send_element(pick_element(profile), $urandom_range(0, 4) == 0);
			random_sent += n_items;
		end

		drain();
		if (sb.errors == 0) begin
			$display("vector_l2_normalizer_core_tb: PASS");
		end else begin
			$display("vector_l2_normalizer_core_tb: FAIL");
		end
		$finish;
	end

endmodule
